@@ rtl/cxp_pkg.sv @@
// Shared constants, types and arithmetic helpers of the complex pair transform.
// Used by every module of the block; depends on nothing.

package cxp_pkg;

    // Field widths
    localparam int AMP_WIDTH      = 16;
    localparam int NORM_ACC_WIDTH = 48;
    localparam int MAT_WIDTH      = 16;
    localparam int MAT_FRAC       = 14;
    localparam int SCALE_WIDTH    = 16;
    localparam int THR_WIDTH      = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_M00       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_M01       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M10       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_M11       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE = 3'd6;

    // Reset values: identity matrix, unity scale
    localparam logic [CFG_DATA_W-1:0]  MAT_ONE   = 32'h4000_0000;
    localparam logic [SCALE_WIDTH-1:0] SCALE_ONE = 16'h4000;

    // Datapath widths
    localparam int PROD_W   = MAT_WIDTH + AMP_WIDTH;
    localparam int SUM_W    = PROD_W + 2;
    localparam int MAG_W    = SUM_W - 1;
    localparam int SCALED_W = MAG_W + SCALE_WIDTH;
    localparam int DROP     = 2 * MAT_FRAC;
    localparam int RND_W    = SCALED_W - DROP + 1;
    localparam int SQ_W     = 2 * AMP_WIDTH;
    localparam int SQ_FB    = 2 * (AMP_WIDTH - 1);
    localparam int SQ_SHR   = (SQ_FB >= 30) ? (SQ_FB - 30) : 0;
    localparam int SQ_SHL   = (SQ_FB >= 30) ? 0 : (30 - SQ_FB);
    localparam int SQX_W    = SQ_W + SQ_SHL;

    // Item queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef logic signed [AMP_WIDTH-1:0] amp_t;

    typedef struct packed {
        amp_t a0_re;
        amp_t a0_im;
        amp_t a1_re;
        amp_t a1_im;
        logic last_pair;
    } item_t;

    // Queue word: the item together with its processing class
    typedef struct packed {
        item_t item;
        logic  norm;
    } q_entry_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0]  m00;
        logic [CFG_DATA_W-1:0]  m01;
        logic [CFG_DATA_W-1:0]  m10;
        logic [CFG_DATA_W-1:0]  m11;
        logic [SCALE_WIDTH-1:0] scale;
        logic [THR_WIDTH-1:0]   flush_threshold;
        logic                   norm_mode;
    } cfg_t;

    typedef struct packed {
        amp_t                      b0_re;
        amp_t                      b0_im;
        amp_t                      b1_re;
        amp_t                      b1_im;
        logic [NORM_ACC_WIDTH-1:0] norm_total;
        logic                      sweep_done;
    } res_t;

    // Round a scaled magnitude half away from zero, drop DROP bits, saturate.
    function automatic amp_t round_sat(input logic neg, input logic [SCALED_W-1:0] scaled);
        logic [SCALED_W:0]  t;
        logic [RND_W-1:0]   mag;
        logic [RND_W-1:0]   lim;
        amp_t               r;
        t   = {1'b0, scaled} + ((SCALED_W + 1)'(1) << (DROP - 1));
        mag = t[SCALED_W:DROP];
        lim = RND_W'(1) << (AMP_WIDTH - 1);
        if (neg) begin
            if (mag > lim) begin
                r = amp_t'(lim);
            end else begin
                r = amp_t'(RND_W'(0) - mag);
            end
        end else begin
            if (mag > lim - RND_W'(1)) begin
                r = amp_t'(lim - RND_W'(1));
            end else begin
                r = amp_t'(mag);
            end
        end
        return r;
    endfunction

    // Bring a squared magnitude to Q2.30 at accumulator width.
    function automatic logic [NORM_ACC_WIDTH-1:0] to_q230(input logic [SQ_W-1:0] sq);
        logic [SQX_W-1:0] x;
        x = (SQX_W'(sq) << SQ_SHL) >> SQ_SHR;
        return NORM_ACC_WIDTH'(x);
    endfunction

endpackage

@@ rtl/cxp_front.sv @@
// Front end: takes input words, tags each with its processing class and
// holds them in a short queue for the back end. Depends on cxp_pkg.

module cxp_front
    import cxp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  item_t    item_in,
    input  logic     norm_mode,
    output logic     full,
    output logic     q_valid,
    input  logic     q_pop,
    output q_entry_t q_entry
);

    q_entry_t          ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = ent_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage: the word is classified by the mode in force when taken.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= '{item: item_in, norm: norm_mode};
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("item queue fill count beyond its depth");

    a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == QCNT_W'($past(cnt_reg) + QCNT_W'(1)))
        else $error("accepted word not counted in the item queue");
`endif

endmodule

@@ rtl/cxp_back.sv @@
// Back end: six-stage pipeline doing the matrix product, scaling, rounding,
// flushing and norm accumulation, with the result held in its last stage.
// Depends on cxp_pkg.

module cxp_back
    import cxp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_valid,
    input  q_entry_t q_entry,
    output logic     q_pop,
    input  logic     pop,
    output logic     empty,
    output res_t     res
);

    logic [5:0] vld_reg, vld_next;
    logic       en;

    // Stage 1: partial products
    logic signed [PROD_W-1:0] s1_prod_reg [2][8];
    logic signed [PROD_W-1:0] s1_prod_next [2][8];
    logic                     s1_norm_reg, s1_last_reg;
    // Stage 2: sums as sign and magnitude
    logic                     s2_neg_reg [4];
    logic                     s2_neg_next [4];
    logic [MAG_W-1:0]         s2_mag_reg [4];
    logic [MAG_W-1:0]         s2_mag_next [4];
    logic                     s2_norm_reg, s2_last_reg;
    // Stage 3: scaled magnitudes
    logic                     s3_neg_reg [4];
    logic [SCALED_W-1:0]      s3_scl_reg [4];
    logic [SCALED_W-1:0]      s3_scl_next [4];
    logic                     s3_norm_reg, s3_last_reg;
    // Stage 4: rounded and saturated values
    amp_t                     s4_val_reg [4];
    amp_t                     s4_val_next [4];
    logic                     s4_norm_reg, s4_last_reg;
    // Stage 5: values with squared magnitudes
    amp_t                     s5_val_reg [4];
    logic [NORM_ACC_WIDTH-1:0] s5_sq_reg [2];
    logic [NORM_ACC_WIDTH-1:0] s5_sq_next [2];
    logic                     s5_norm_reg, s5_last_reg;
    // Stage 6: result and running norm
    res_t                     res_reg, res_next;
    logic [NORM_ACC_WIDTH-1:0] acc_reg, acc_next;

    logic [CFG_DATA_W-1:0]    mrow [2][2];
    logic [SCALE_WIDTH-1:0]   factor;

    // The whole pipeline advances unless a finished result is waiting and pop is low.
    assign en    = !vld_reg[5] || pop;
    assign q_pop = en && q_valid;
    assign empty = !vld_reg[5];
    assign res   = res_reg;

    assign mrow[0][0] = cfg.m00;
    assign mrow[0][1] = cfg.m01;
    assign mrow[1][0] = cfg.m10;
    assign mrow[1][1] = cfg.m11;

    assign vld_next = {vld_reg[4:0], q_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: sixteen products of matrix halves and amplitudes.
    always_comb
    begin
        logic signed [MAT_WIDTH-1:0] pr, pi, qr, qi;
        for (int k = 0; k < 2; k++)
        begin
            pr = mrow[k][0][2*MAT_WIDTH-1:MAT_WIDTH];
            pi = mrow[k][0][MAT_WIDTH-1:0];
            qr = mrow[k][1][2*MAT_WIDTH-1:MAT_WIDTH];
            qi = mrow[k][1][MAT_WIDTH-1:0];
            s1_prod_next[k][0] = pr * q_entry.item.a0_re;
            s1_prod_next[k][1] = pi * q_entry.item.a0_im;
            s1_prod_next[k][2] = qr * q_entry.item.a1_re;
            s1_prod_next[k][3] = qi * q_entry.item.a1_im;
            s1_prod_next[k][4] = pr * q_entry.item.a0_im;
            s1_prod_next[k][5] = pi * q_entry.item.a0_re;
            s1_prod_next[k][6] = qr * q_entry.item.a1_im;
            s1_prod_next[k][7] = qi * q_entry.item.a1_re;
        end
    end

    // Stage 2: complex sums, split into sign and magnitude.
    always_comb
    begin
        logic signed [SUM_W-1:0] sre, sim;
        for (int k = 0; k < 2; k++)
        begin
            sre = SUM_W'(s1_prod_reg[k][0]) - SUM_W'(s1_prod_reg[k][1])
                + SUM_W'(s1_prod_reg[k][2]) - SUM_W'(s1_prod_reg[k][3]);
            sim = SUM_W'(s1_prod_reg[k][4]) + SUM_W'(s1_prod_reg[k][5])
                + SUM_W'(s1_prod_reg[k][6]) + SUM_W'(s1_prod_reg[k][7]);
            s2_neg_next[2*k]     = sre[SUM_W-1];
            s2_neg_next[2*k + 1] = sim[SUM_W-1];
            s2_mag_next[2*k]     = sre[SUM_W-1] ? MAG_W'(-sre) : MAG_W'(sre);
            s2_mag_next[2*k + 1] = sim[SUM_W-1] ? MAG_W'(-sim) : MAG_W'(sim);
        end
    end

    // Stage 3: plain mode scales by one so both modes round the same bits.
    assign factor = s2_norm_reg ? cfg.scale : SCALE_ONE;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            s3_scl_next[j] = SCALED_W'(s2_mag_reg[j]) * SCALED_W'(factor);
        end
    end

    // Stage 4: rounding and saturation.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            s4_val_next[j] = round_sat(s3_neg_reg[j], s3_scl_reg[j]);
        end
    end

    // Stage 5: squared magnitude of each result in Q2.30.
    always_comb
    begin
        logic signed [SQ_W-1:0] re2, im2;
        for (int k = 0; k < 2; k++)
        begin
            re2 = s4_val_reg[2*k] * s4_val_reg[2*k];
            im2 = s4_val_reg[2*k + 1] * s4_val_reg[2*k + 1];
            s5_sq_next[k] = to_q230(SQ_W'(re2) + SQ_W'(im2));
        end
    end

    // Stage 6: flush small results, accumulate kept ones, report on last.
    always_comb
    begin
        logic                      keep0, keep1;
        logic [NORM_ACC_WIDTH+1:0] sum;
        logic [NORM_ACC_WIDTH-1:0] sat;
        keep0 = s5_norm_reg && !(s5_sq_reg[0] < NORM_ACC_WIDTH'(cfg.flush_threshold));
        keep1 = s5_norm_reg && !(s5_sq_reg[1] < NORM_ACC_WIDTH'(cfg.flush_threshold));
        sum   = (NORM_ACC_WIDTH + 2)'(acc_reg)
              + (keep0 ? (NORM_ACC_WIDTH + 2)'(s5_sq_reg[0]) : '0)
              + (keep1 ? (NORM_ACC_WIDTH + 2)'(s5_sq_reg[1]) : '0);
        sat   = (sum[NORM_ACC_WIDTH+1:NORM_ACC_WIDTH] != 2'b00) ? '1
              : sum[NORM_ACC_WIDTH-1:0];
        // A flush applies only in normalising mode.
        res_next.b0_re      = (s5_norm_reg && !keep0) ? amp_t'(0) : s5_val_reg[0];
        res_next.b0_im      = (s5_norm_reg && !keep0) ? amp_t'(0) : s5_val_reg[1];
        res_next.b1_re      = (s5_norm_reg && !keep1) ? amp_t'(0) : s5_val_reg[2];
        res_next.b1_im      = (s5_norm_reg && !keep1) ? amp_t'(0) : s5_val_reg[3];
        res_next.norm_total = s5_last_reg ? sat : '0;
        res_next.sweep_done = s5_last_reg;
        acc_next            = s5_last_reg ? '0 : sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (en && vld_reg[4])
        begin
            acc_reg <= acc_next;
        end
    end

    // Pipeline payload moves on with the stage valid bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_norm_reg <= q_entry.norm;
            s1_last_reg <= q_entry.item.last_pair;
            s2_neg_reg  <= s2_neg_next;
            s2_mag_reg  <= s2_mag_next;
            s2_norm_reg <= s1_norm_reg;
            s2_last_reg <= s1_last_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_scl_reg  <= s3_scl_next;
            s3_norm_reg <= s2_norm_reg;
            s3_last_reg <= s2_last_reg;
            s4_val_reg  <= s4_val_next;
            s4_norm_reg <= s3_norm_reg;
            s4_last_reg <= s3_last_reg;
            s5_val_reg  <= s4_val_reg;
            s5_sq_reg   <= s5_sq_next;
            s5_norm_reg <= s4_norm_reg;
            s5_last_reg <= s4_last_reg;
            res_reg     <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[5] && !pop) |=> vld_reg[5] && $stable(res_reg))
        else $error("waiting result lost or altered while stalled");

    a_norm_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[5] && !res_reg.sweep_done) |-> res_reg.norm_total == '0)
        else $error("norm reported on a result that does not end the sweep");

    a_norm_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[4] && s5_last_reg) |=> acc_reg == '0)
        else $error("running norm not cleared after the last pair");
`endif

endmodule

@@ rtl/complex_2x2_pair_transform_core.sv @@
// Top level of the complex 2x2 pair transform: configuration registers,
// front end with item queue, and back-end pipeline. Depends on cxp_pkg,
// cxp_front and cxp_back.
//
// Usage:
//  - Input channel: present a0/a1 and last_pair with push; a word is taken at
//    a clock edge where push is high and full is low.
//  - Result channel: while empty is low the oldest result is on b0/b1,
//    norm_total and sweep_done; it is taken at an edge where pop is high.
//  - Configuration: write wr_data to register wr_index while wr_en is high;
//    registers are m00, m01, m10, m11, scale, flush_threshold, norm_mode.
//    Write only while no word is in flight.
//  - Path: a taken word waits in the item queue, then passes the five pipeline
//    stages before the result stage.
//  - Throughput: one word per cycle while results are taken, set by the
//    six-stage back-end pipeline whose multipliers each take one stage.
//  - When pop is held low the pipeline freezes behind the waiting result and
//    the four-word item queue fills; full then rises.
//  - Reset empties queue and pipeline, clears the running norm and loads the
//    identity matrix, unity scale, zero threshold and plain mode.

module complex_2x2_pair_transform_core
    import cxp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input words
    input  logic                      push,
    output logic                      full,
    input  amp_t                      a0_re,
    input  amp_t                      a0_im,
    input  amp_t                      a1_re,
    input  amp_t                      a1_im,
    input  logic                      last_pair,
    // results
    output logic                      empty,
    input  logic                      pop,
    output amp_t                      b0_re,
    output amp_t                      b0_im,
    output amp_t                      b1_re,
    output amp_t                      b1_im,
    output logic [NORM_ACC_WIDTH-1:0] norm_total,
    output logic                      sweep_done,
    // configuration writes
    input  logic                      wr_en,
    input  logic [CFG_IDX_W-1:0]      wr_index,
    input  logic [CFG_DATA_W-1:0]     wr_data
);

    cfg_t     cfg_reg;
    item_t    item_in;
    q_entry_t q_entry;
    logic     q_valid;
    logic     q_pop;
    res_t     res;

    // Configuration register file; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.m00             <= MAT_ONE;
            cfg_reg.m01             <= '0;
            cfg_reg.m10             <= '0;
            cfg_reg.m11             <= MAT_ONE;
            cfg_reg.scale           <= SCALE_ONE;
            cfg_reg.flush_threshold <= '0;
            cfg_reg.norm_mode       <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_M00:       cfg_reg.m00             <= wr_data;
                REG_M01:       cfg_reg.m01             <= wr_data;
                REG_M10:       cfg_reg.m10             <= wr_data;
                REG_M11:       cfg_reg.m11             <= wr_data;
                REG_SCALE:     cfg_reg.scale           <= wr_data[SCALE_WIDTH-1:0];
                REG_THRESHOLD: cfg_reg.flush_threshold <= wr_data[THR_WIDTH-1:0];
                REG_NORM_MODE: cfg_reg.norm_mode       <= wr_data[0];
                default:       ;
            endcase
        end
    end

    assign item_in = '{a0_re: a0_re, a0_im: a0_im, a1_re: a1_re, a1_im: a1_im,
                       last_pair: last_pair};

    // Front end and item queue.
    cxp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item_in   (item_in),
        .norm_mode (cfg_reg.norm_mode),
        .full      (full),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry)
    );

    // Arithmetic pipeline and result stage.
    cxp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign b0_re      = res.b0_re;
    assign b0_im      = res.b0_im;
    assign b1_re      = res.b1_re;
    assign b1_im      = res.b1_im;
    assign norm_total = res.norm_total;
    assign sweep_done = res.sweep_done;

endmodule

@@ test/cxp_pair_checker.sv @@
// Result checker for the complex 2x2 pair transform: follows the input, result and
// register write channels, predicts each result word and compares it field by field.
// Depends on cxp_pkg for the field, register and word types.
`timescale 1ns / 1ps

module cxp_pair_checker
    import cxp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      full,
    input  amp_t                      a0_re,
    input  amp_t                      a0_im,
    input  amp_t                      a1_re,
    input  amp_t                      a1_im,
    input  logic                      last_pair,
    input  logic                      empty,
    input  logic                      pop,
    input  amp_t                      b0_re,
    input  amp_t                      b0_im,
    input  amp_t                      b1_re,
    input  amp_t                      b1_im,
    input  logic [NORM_ACC_WIDTH-1:0] norm_total,
    input  logic                      sweep_done,
    input  logic                      wr_en,
    input  logic [CFG_IDX_W-1:0]      wr_index,
    input  logic [CFG_DATA_W-1:0]     wr_data,
    output int                        mismatches,
    output int                        pending
);

    typedef logic signed [MAT_WIDTH-1:0] coef_t;

    localparam longint AMP_LIM = longint'(1) << (AMP_WIDTH - 1);
    localparam logic [NORM_ACC_WIDTH-1:0] NORM_MAX = '1;

    cfg_t                      gate_cfg;
    logic [NORM_ACC_WIDTH-1:0] sweep_norm;
    res_t                      expected_words[$];
    res_t                      seen;
    res_t                      want;
    int                        words_seen;

    // Every failure goes through here: one line, one count.
    task automatic report_mismatch(input string what);
        $display("mismatch at word %0d: %s", words_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string field, input longint got, input longint exp_val);
        if (got != exp_val) begin
            report_mismatch($sformatf("%s got %0d expected %0d", field, got, exp_val));
        end
    endtask

    // Queue the prediction for a word behind those already waiting.
    task automatic store_expected(input res_t w);
        expected_words.insert(expected_words.size(), w);
    endtask

    // Rescale a signed sum: apply the factor to the magnitude, round half away
    // from zero while dropping the fraction bits, then saturate to the amplitude.
    function automatic amp_t round_amp(input longint sum, input longint factor, input int drop);
        logic   neg;
        longint mag;
        neg = sum < 0;
        mag = neg ? -sum : sum;
        mag = mag * factor;
        mag = (mag + (longint'(1) << (drop - 1))) >> drop;
        if (neg) begin
            return (mag > AMP_LIM) ? amp_t'(-AMP_LIM) : amp_t'(-mag);
        end
        return (mag > AMP_LIM - 1) ? amp_t'(AMP_LIM - 1) : amp_t'(mag);
    endfunction

    // Squared magnitude of a saturated result, brought to Q2.30.
    function automatic logic [NORM_ACC_WIDTH-1:0] mag_sq(input amp_t re, input amp_t im);
        longint r;
        longint i;
        longint s;
        r = (re < 0) ? -longint'(re) : longint'(re);
        i = (im < 0) ? -longint'(im) : longint'(im);
        s = r * r + i * i;
        s = (s << SQ_SHL) >> SQ_SHR;
        return NORM_ACC_WIDTH'(s);
    endfunction

    // Expected result word for one input word; updates the running norm.
    function automatic res_t transform_pair(input item_t it);
        res_t                      r;
        longint                    ar0, ai0, ar1, ai1;
        longint                    pr, pi, qr, qi, sre, sim;
        logic [CFG_DATA_W-1:0]     pm, qm;
        amp_t                      re[2];
        amp_t                      im[2];
        logic [NORM_ACC_WIDTH-1:0] sq;
        ar0 = longint'(it.a0_re);
        ai0 = longint'(it.a0_im);
        ar1 = longint'(it.a1_re);
        ai1 = longint'(it.a1_im);
        for (int k = 0; k < 2; k++) begin
            pm  = (k == 0) ? gate_cfg.m00 : gate_cfg.m10;
            qm  = (k == 0) ? gate_cfg.m01 : gate_cfg.m11;
            pr  = longint'(coef_t'(pm[CFG_DATA_W-1:MAT_WIDTH]));
            pi  = longint'(coef_t'(pm[MAT_WIDTH-1:0]));
            qr  = longint'(coef_t'(qm[CFG_DATA_W-1:MAT_WIDTH]));
            qi  = longint'(coef_t'(qm[MAT_WIDTH-1:0]));
            sre = pr * ar0 - pi * ai0 + qr * ar1 - qi * ai1;
            sim = pr * ai0 + pi * ar0 + qr * ai1 + qi * ar1;
            if (gate_cfg.norm_mode) begin
                re[k] = round_amp(sre, longint'(gate_cfg.scale), 2 * MAT_FRAC);
                im[k] = round_amp(sim, longint'(gate_cfg.scale), 2 * MAT_FRAC);
                sq    = mag_sq(re[k], im[k]);
                if (sq < NORM_ACC_WIDTH'(gate_cfg.flush_threshold)) begin
                    re[k] = '0;
                    im[k] = '0;
                end else if (sq > NORM_MAX - sweep_norm) begin
                    sweep_norm = NORM_MAX;
                end else begin
                    sweep_norm = sweep_norm + sq;
                end
            end else begin
                re[k] = round_amp(sre, 1, MAT_FRAC);
                im[k] = round_amp(sim, 1, MAT_FRAC);
            end
        end
        r.b0_re = re[0];
        r.b0_im = im[0];
        r.b1_re = re[1];
        r.b1_im = im[1];
        if (it.last_pair) begin
            r.norm_total = sweep_norm;
            r.sweep_done = 1'b1;
            sweep_norm   = '0;
        end else begin
            r.norm_total = '0;
            r.sweep_done = 1'b0;
        end
        return r;
    endfunction

    // All three channels are sampled at the clock edge, before the block and
    // the stimulus update anything.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gate_cfg = '{m00: MAT_ONE, m01: '0, m10: '0, m11: MAT_ONE,
                         scale: SCALE_ONE, flush_threshold: '0, norm_mode: 1'b0};
            sweep_norm = '0;
            expected_words.delete();
            words_seen = 0;
            mismatches = 0;
            pending    = 0;
        end else begin
            // Result side: compare with the oldest expectation.
            if (pop && !empty) begin
                seen = '{b0_re: b0_re, b0_im: b0_im, b1_re: b1_re, b1_im: b1_im,
                         norm_total: norm_total, sweep_done: sweep_done};
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_words.pop_front();
                    check_field("b0_re", seen.b0_re, want.b0_re);
                    check_field("b0_im", seen.b0_im, want.b0_im);
                    check_field("b1_re", seen.b1_re, want.b1_re);
                    check_field("b1_im", seen.b1_im, want.b1_im);
                    check_field("norm_total", longint'(seen.norm_total),
                                longint'(want.norm_total));
                    check_field("sweep_done", seen.sweep_done, want.sweep_done);
                end
                words_seen++;
            end
            // Input side: predict the word just taken.
            if (push && !full) begin
                store_expected(transform_pair('{a0_re: a0_re, a0_im: a0_im,
                    a1_re: a1_re, a1_im: a1_im, last_pair: last_pair}));
            end
            // Register writes; an unused index changes nothing.
            if (wr_en) begin
                case (wr_index)
                    REG_M00:       gate_cfg.m00 = wr_data;
                    REG_M01:       gate_cfg.m01 = wr_data;
                    REG_M10:       gate_cfg.m10 = wr_data;
                    REG_M11:       gate_cfg.m11 = wr_data;
                    REG_SCALE:     gate_cfg.scale = wr_data[SCALE_WIDTH-1:0];
                    REG_THRESHOLD: gate_cfg.flush_threshold = wr_data[THR_WIDTH-1:0];
                    REG_NORM_MODE: gate_cfg.norm_mode = wr_data[0];
                    default: ;
                endcase
            end
            pending = expected_words.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// Top of the pair transform testbench: clock, reset, register settings and word
// stimulus with random idling. Depends on cxp_pkg, complex_2x2_pair_transform_core
// and cxp_pair_checker, which predicts and compares the results.
`timescale 1ns / 1ps

module testbench;
    import cxp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam amp_t AMP_MAX     = {1'b0, {(AMP_WIDTH-1){1'b1}}};
    localparam amp_t AMP_MIN     = {1'b1, {(AMP_WIDTH-1){1'b0}}};
    localparam int   CYCLE_LIMIT = 600_000;
    localparam int   SETTLE      = 10;
    localparam int   RAND_PHASES = 8;
    localparam int   PHASE_WORDS = 200;
    localparam int   CALM_WORDS  = 150;
    // Length of the closing sweep of saturated words.
    localparam int   LONG_SWEEP  = 100;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    amp_t                      a0_re = '0;
    amp_t                      a0_im = '0;
    amp_t                      a1_re = '0;
    amp_t                      a1_im = '0;
    logic                      last_pair = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    amp_t                      b0_re;
    amp_t                      b0_im;
    amp_t                      b1_re;
    amp_t                      b1_im;
    logic [NORM_ACC_WIDTH-1:0] norm_total;
    logic                      sweep_done;
    logic                      wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      wr_index = '0;
    logic [CFG_DATA_W-1:0]     wr_data = '0;

    int   mismatches;
    int   pending;
    int   cycle_count = 0;
    logic idle_on = 1'b1;

    complex_2x2_pair_transform_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .a0_re      (a0_re),
        .a0_im      (a0_im),
        .a1_re      (a1_re),
        .a1_im      (a1_im),
        .last_pair  (last_pair),
        .empty      (empty),
        .pop        (pop),
        .b0_re      (b0_re),
        .b0_im      (b0_im),
        .b1_re      (b1_re),
        .b1_im      (b1_im),
        .norm_total (norm_total),
        .sweep_done (sweep_done),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    cxp_pair_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .a0_re      (a0_re),
        .a0_im      (a0_im),
        .a1_re      (a1_re),
        .a1_im      (a1_im),
        .last_pair  (last_pair),
        .empty      (empty),
        .pop        (pop),
        .b0_re      (b0_re),
        .b0_im      (b0_im),
        .b1_re      (b1_re),
        .b1_im      (b1_im),
        .norm_total (norm_total),
        .sweep_done (sweep_done),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: take words, with random stall bursts while idling is on.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // Present one word and hold it until it is taken.
    task automatic send_word(input amp_t x0r, input amp_t x0i, input amp_t x1r,
                             input amp_t x1i, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        push      <= 1'b1;
        a0_re     <= x0r;
        a0_im     <= x0i;
        a1_re     <= x1r;
        a1_im     <= x1i;
        last_pair <= lst;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // Stop sending and let every outstanding word come back.
    task automatic drain_words();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(input cfg_t c);
        write_reg(REG_M00, c.m00);
        write_reg(REG_M01, c.m01);
        write_reg(REG_M10, c.m10);
        write_reg(REG_M11, c.m11);
        write_reg(REG_SCALE, CFG_DATA_W'(c.scale));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(c.flush_threshold));
        write_reg(REG_NORM_MODE, CFG_DATA_W'(c.norm_mode));
        wr_en <= 1'b0;
    endtask

    // Amplitudes lean towards the extremes and towards zero.
    function automatic amp_t rand_amp();
        case ($urandom_range(0, 7))
            0: return AMP_MAX;
            1: return AMP_MIN;
            2: return amp_t'($urandom_range(0, 64)) - amp_t'(32);
            default: return amp_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_entry();
        case ($urandom_range(0, 6))
            0: return MAT_ONE;
            1: return 32'h8000_8000;
            2: return 32'h7FFF_7FFF;
            3: return 32'h2D41_0000;    // roughly one over root two
            4: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.m00 = rand_entry();
        c.m01 = rand_entry();
        c.m10 = rand_entry();
        c.m11 = rand_entry();
        case ($urandom_range(0, 5))
            0: c.scale = '0;
            1: c.scale = '1;
            2: c.scale = SCALE_ONE;
            3: c.scale = 16'h2D41;
            default: c.scale = SCALE_WIDTH'($urandom);
        endcase
        case ($urandom_range(0, 6))
            0: c.flush_threshold = '0;
            1: c.flush_threshold = '1;
            2: c.flush_threshold = $urandom_range(0, 32'h1000_0000);
            3: c.flush_threshold = $urandom_range(0, 32'h0100_0000);
            4: c.flush_threshold = $urandom_range(0, 32'h0010_0000);
            default: c.flush_threshold = $urandom;
        endcase
        c.norm_mode = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Random sweeps: words with random content, a sweep ending about one in twelve.
    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_word(rand_amp(), rand_amp(), rand_amp(), rand_amp(),
                      ($urandom_range(0, 11) == 0) || (n == count - 1));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: identity matrix in plain mode, last word with an empty norm.
        send_word(AMP_MIN, AMP_MIN, AMP_MAX, AMP_MAX, 1'b0);
        send_word(AMP_MAX, AMP_MIN, '0, -16'sd1, 1'b1);
        send_word('0, '0, '0, '0, 1'b1);
        drain_words();

        // Plain mode saturation with extreme coefficients; the unused index is ignored.
        write_reg(REG_UNUSED, '1);
        configure('{m00: 32'h8000_8000, m01: 32'h7FFF_7FFF, m10: 32'h8000_0000,
                    m11: 32'h0000_8000, scale: 16'hFFFF, flush_threshold: '0,
                    norm_mode: 1'b0});
        send_word(AMP_MIN, AMP_MIN, AMP_MIN, AMP_MIN, 1'b0);
        send_word(AMP_MAX, AMP_MAX, AMP_MAX, AMP_MAX, 1'b0);
        send_word(AMP_MAX, AMP_MIN, AMP_MIN, AMP_MAX, 1'b0);
        send_word(16'sd1, -16'sd1, 16'sd3, -16'sd3, 1'b1);
        drain_words();

        // Half scale in normalising mode: halves round away from zero, no flushing.
        configure('{m00: MAT_ONE, m01: '0, m10: '0, m11: MAT_ONE, scale: 16'h2000,
                    flush_threshold: '0, norm_mode: 1'b1});
        send_word(16'sd1, -16'sd1, 16'sd3, -16'sd3, 1'b0);
        send_word(AMP_MIN, AMP_MAX, AMP_MAX, AMP_MIN, 1'b0);
        send_word('0, '0, -16'sd5, 16'sd7, 1'b0);
        send_word(AMP_MAX, AMP_MAX, AMP_MIN, AMP_MIN, 1'b1);
        drain_words();

        // Threshold at a quarter plus a quarter: exactly equal is kept, just below flushed.
        configure('{m00: MAT_ONE, m01: '0, m10: '0, m11: MAT_ONE, scale: SCALE_ONE,
                    flush_threshold: 32'h2000_0000, norm_mode: 1'b1});
        send_word(16'sd16384, 16'sd16384, 16'sd16383, 16'sd16384, 1'b0);
        send_word(16'sd16383, -16'sd16384, AMP_MIN, AMP_MIN, 1'b0);
        send_word(-16'sd16384, -16'sd16384, '0, '0, 1'b1);
        drain_words();

        // Largest threshold flushes everything.
        configure('{m00: 32'h7FFF_7FFF, m01: MAT_ONE, m10: 32'h8000_8000, m11: MAT_ONE,
                    scale: 16'hFFFF, flush_threshold: '1, norm_mode: 1'b1});
        send_word(AMP_MAX, AMP_MAX, AMP_MAX, AMP_MAX, 1'b0);
        send_word(AMP_MIN, AMP_MAX, AMP_MIN, AMP_MAX, 1'b1);
        drain_words();

        // Random settings, each phase started from an idle block.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            configure(rand_cfg());
            random_phase(PHASE_WORDS);
            drain_words();
        end

        // Final stretch without any idling on either side.
        idle_on = 1'b0;
        configure(rand_cfg());
        random_phase(CALM_WORDS);
        drain_words();

        // One sweep of saturated words builds a large running norm.
        configure('{m00: 32'h7FFF_7FFF, m01: 32'h7FFF_7FFF, m10: 32'h7FFF_7FFF,
                    m11: 32'h7FFF_7FFF, scale: 16'hFFFF, flush_threshold: '0,
                    norm_mode: 1'b1});
        for (int n = 0; n < LONG_SWEEP; n++)
        begin
            send_word(AMP_MAX, '0, AMP_MAX, '0, n == LONG_SWEEP - 1);
        end
        drain_words();

        @(negedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
